// ----- src/fpr_pkg.sv -----
// Shared constants, types and state encoding for the FIFO page replacement unit.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int IN_W      = 16;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int FCNT_W    = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;   // latch reference, clear search index
    logic step;    // compare one frame, advance index
    logic commit;  // apply miss update, load result register
  } cmd_t;

  typedef struct packed {
    logic match;   // current frame is valid and holds the page
    logic last;    // current frame is the final one in use
  } status_t;

endpackage

// ----- src/fpr_ctrl.sv -----
// Controller state machine: sequences accept, frame search and result hand-off.
`timescale 1ns / 1ps

module fpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fpr_pkg::status_t status,
  output fpr_pkg::cmd_t    cmd
);

  fpr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      fpr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = fpr_pkg::ST_SEARCH;
        end
      end
      fpr_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.match || status.last) begin
          state_nxt = fpr_pkg::ST_DONE;
        end
      end
      fpr_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/fpr_datapath.sv -----
// Datapath: frame table, valid bits, FIFO pointer, fault counter and result register.
`timescale 1ns / 1ps

module fpr_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [fpr_pkg::IN_W-1:0]     in_page_number,
  input  fpr_pkg::cmd_t                cmd,
  output fpr_pkg::status_t             status,
  output logic                         out_fault,
  output logic [fpr_pkg::FCNT_W-1:0]   out_fault_count
);

  logic [fpr_pkg::PAGE_BITS-1:0] frame_pages [fpr_pkg::FRAMES];
  logic [fpr_pkg::FRAMES-1:0]    frame_valid_r, frame_valid_nxt;

  logic [fpr_pkg::CFG_W-1:0]     frames_cfg_r;
  logic [fpr_pkg::CNT_W-1:0]     n_eff;
  logic [fpr_pkg::CNT_W-1:0]     n_r;
  logic [fpr_pkg::PAGE_BITS-1:0] page_r;
  logic [fpr_pkg::PAGE_BITS-1:0] rd_page_r;
  logic [fpr_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic                          hit_r;
  logic [fpr_pkg::IDX_W-1:0]     fill_ptr_r, fill_ptr_nxt;
  logic [fpr_pkg::FCNT_W-1:0]    fault_total_r, fault_total_nxt;
  logic                          out_fault_r;
  logic [fpr_pkg::FCNT_W-1:0]    out_fault_count_r;

  logic [fpr_pkg::IDX_W-1:0]     slot;
  logic [fpr_pkg::CNT_W-1:0]     slot_inc;

  // clamp frame count to 1..FRAMES
  always_comb begin
    if (frames_cfg_r == '0) begin
      n_eff = fpr_pkg::CNT_W'(1);
    end else if (32'(frames_cfg_r) > fpr_pkg::FRAMES) begin
      n_eff = fpr_pkg::CNT_W'(fpr_pkg::FRAMES);
    end else begin
      n_eff = fpr_pkg::CNT_W'(frames_cfg_r);
    end
  end

  // rd_page_r already holds the entry at idx_r
  assign status.match = frame_valid_r[idx_r] && (rd_page_r == page_r);
  assign status.last  = (fpr_pkg::CNT_W'(idx_r) + fpr_pkg::CNT_W'(1)) == n_r;
  assign idx_nxt      = idx_r + fpr_pkg::IDX_W'(1);

  // victim slot; a stale pointer past the count restarts at frame 0
  always_comb begin
    slot = (fpr_pkg::CNT_W'(fill_ptr_r) >= n_r) ? '0 : fill_ptr_r;
    slot_inc = fpr_pkg::CNT_W'(slot) + fpr_pkg::CNT_W'(1);
    fill_ptr_nxt = (slot_inc >= n_r) ? '0 : slot_inc[fpr_pkg::IDX_W-1:0];
    fault_total_nxt = (fault_total_r == '1) ? fault_total_r
                                            : fault_total_r + fpr_pkg::FCNT_W'(1);
    frame_valid_nxt = frame_valid_r;
    frame_valid_nxt[slot] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r  <= fpr_pkg::CFG_RESET;
      frame_valid_r <= '0;
      fill_ptr_r    <= '0;
      fault_total_r <= '0;
    end else begin
      if (cfg_we) begin
        frames_cfg_r <= cfg_wdata;
      end
      if (cmd.commit && !hit_r) begin
        frame_valid_r <= frame_valid_nxt;
        fill_ptr_r    <= fill_ptr_nxt;
        fault_total_r <= fault_total_nxt;
      end
    end
  end

  // frame table write and registered read, fetched one frame ahead of the compare
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) begin
      frame_pages[slot] <= page_r;
    end
    if (cmd.start) begin
      rd_page_r <= frame_pages[fpr_pkg::IDX_W'(0)];
    end else if (cmd.step) begin
      rd_page_r <= frame_pages[idx_nxt];
    end
  end

  // search registers and result register (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r <= in_page_number[fpr_pkg::PAGE_BITS-1:0];
      n_r    <= n_eff;
      idx_r  <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_nxt;
      hit_r <= status.match;
    end
    if (cmd.commit) begin
      out_fault_r       <= !hit_r;
      out_fault_count_r <= hit_r ? fault_total_r : fault_total_nxt;
    end
  end

  assign out_fault       = out_fault_r;
  assign out_fault_count = out_fault_count_r;

endmodule

// ----- src/fifo_page_replacement_unit.sv -----
// Top level of the FIFO page replacement unit: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// -------   ---------------------------------------   ---------
// input     in_valid, in_ready, in_page_number        sink
// result    out_valid, out_ready, out_fault,          source
//           out_fault_count
// config    cfg_we, cfg_wdata (frames_in_use)         sink
//
// Each reference, with N = frames in use (1..16), goes through accept, then
// one frame compare per cycle until a hit or the last frame, then a commit
// that updates the table on a miss and loads the result register. A miss
// compares all N frames; a hit in frame k (from 0) ends the search there.
// The result register lets the next reference be accepted and searched while
// the previous result still waits; commit stalls only if that register is full.
// Synchronous active-low reset empties all frames, zeroes the FIFO pointer and
// fault counter and sets frames_in_use to 16.

module fifo_page_replacement_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fpr_pkg::IN_W-1:0]       in_page_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_fault,
  output logic [fpr_pkg::FCNT_W-1:0]     out_fault_count
);

  fpr_pkg::cmd_t    cmd;     // controller -> datapath
  fpr_pkg::status_t status;  // datapath -> controller

  // sequencing: accept, per-frame search, commit/hand-off of each transfer
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // frame table, FIFO pointer, saturating fault counter, result register
  fpr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_page_number  (in_page_number),
    .cmd             (cmd),
    .status          (status),
    .out_fault       (out_fault),
    .out_fault_count (out_fault_count)
  );

endmodule

// ----- tb/fifo_page_replacement_unit_tb.sv -----
// Self-checking testbench for the FIFO page replacement unit with a built-in frame table predictor.
`timescale 1ns / 1ps

module fifo_page_replacement_unit_tb;

  // Sizing of the run
  localparam int PAGE_COUNT    = 1950;   // random references, roughly
  localparam int STALL_LIMIT   = 2000;   // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 40;     // quiet time after the last result
  localparam int CALM_FROM     = 8000;   // cycle window with no idling on either side
  localparam int CALM_TO       = 14000;
  localparam int IDLE_PCT      = 8;

  // Frame counts for the first random phases: extremes first, then random
  localparam int PHASE_FRAMES [8] = '{16, 1, 31, 0, 5, 12, 2, 17};

  typedef enum logic [1:0] {
    REQ_PAGE,    // one page reference
    REQ_FRAMES,  // frames_in_use write, issued only when nothing is in flight
    REQ_DRAIN    // hold the sender until every result has come back
  } req_kind_t;

  typedef struct {
    req_kind_t                  kind;
    logic [fpr_pkg::IN_W-1:0]   page;
    logic [fpr_pkg::CFG_W-1:0]  frames;
  } page_req_t;

  typedef struct packed {
    logic                       fault;
    logic [fpr_pkg::FCNT_W-1:0] count;
  } fault_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [fpr_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [fpr_pkg::IN_W-1:0]   in_page_number = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_fault;
  logic [fpr_pkg::FCNT_W-1:0] out_fault_count;

  fifo_page_replacement_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fault       (out_fault),
    .out_fault_count (out_fault_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the frame table
  // ---------------------------------------------------------------------------
  logic [fpr_pkg::PAGE_BITS-1:0] frame_page_q [fpr_pkg::FRAMES];
  logic                          frame_held_q [fpr_pkg::FRAMES];
  int                            fill_slot_q;
  logic [fpr_pkg::FCNT_W-1:0]    fault_total_q;
  logic [fpr_pkg::CFG_W-1:0]     frames_cfg_q;

  page_req_t      refs_pending [$];       // stimulus not yet handed to the driver
  fault_result_t  fault_results_due [$];  // predictions waiting for their transfer
  int             pages_queued;
  int             mismatches;
  int             cycle_no;
  int             quiet_cycles;
  int             settle_left;
  logic           page_xfer;              // input transfer seen at the last rising edge
  logic           calm;

  assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  // Look up one reference in the predicted table; on a miss load it FIFO-style.
  function automatic fault_result_t fifo_lookup(input logic [fpr_pkg::IN_W-1:0] page_in);
    int                            n;
    int                            slot;
    logic                          hit;
    logic [fpr_pkg::PAGE_BITS-1:0] pg;
    fault_result_t                 r;
    // zero frames acts as one, anything past the table size is clipped
    n = (frames_cfg_q == '0) ? 1 :
        ((int'(frames_cfg_q) > fpr_pkg::FRAMES) ? fpr_pkg::FRAMES : int'(frames_cfg_q));
    pg = page_in[fpr_pkg::PAGE_BITS-1:0];
    hit = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (frame_held_q[i] && frame_page_q[i] == pg) hit = 1'b1;
    end
    if (!hit) begin
      // pointer left past the count after a shrink restarts at frame 0
      slot = (fill_slot_q >= n) ? 0 : fill_slot_q;
      frame_page_q[slot] = pg;
      frame_held_q[slot] = 1'b1;
      slot++;
      if (slot >= n) slot = 0;
      fill_slot_q = slot;
      if (fault_total_q != '1) fault_total_q++;
    end
    r.fault = !hit;
    r.count = fault_total_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_page(input logic [fpr_pkg::IN_W-1:0] p);
    refs_pending.push_back('{kind: REQ_PAGE, page: p, frames: '0});
    pages_queued++;
  endtask

  task automatic queue_frames(input logic [fpr_pkg::CFG_W-1:0] f);
    refs_pending.push_back('{kind: REQ_FRAMES, page: '0, frames: f});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and reset
  // ---------------------------------------------------------------------------
  initial begin
    int                         phase;
    int                         len;
    int                         span;
    int                         pick;
    logic [fpr_pkg::IN_W-1:0]   base;
    logic [fpr_pkg::IN_W-1:0]   page;
    logic [fpr_pkg::CFG_W-1:0]  frames;

    pages_queued = 0;

    // Default 16 frames: field extremes, alternating bit patterns, hits on both
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h5555);
    queue_page(16'hAAAA);
    queue_page(16'h8000);
    queue_page(16'h0001);
    // Zero frames behaves as one; pointer sits at 6, beyond the count
    queue_frames(fpr_pkg::CFG_W'(0));
    queue_page(16'h0007);
    queue_page(16'h0007);
    queue_page(16'h0009);
    queue_page(16'h0007);
    // Count above the table clips to 16, older frames visible again
    queue_frames(fpr_pkg::CFG_W'(31));
    queue_page(16'hAAAA);
    queue_page(16'h0003);
    queue_page(16'hFFFF);
    // Shrink to two: higher frames are kept but ignored by the search
    queue_frames(fpr_pkg::CFG_W'(2));
    queue_page(16'd100);
    queue_page(16'd101);
    queue_page(16'd100);
    queue_page(16'h8000);
    // Grow back: the frames that were hidden hit again
    queue_frames(fpr_pkg::CFG_W'(16));
    queue_page(16'h0001);
    queue_page(16'h5555);

    // Random phases, each with its own frame count and a local working set
    // so that hits, misses and evictions all show up
    phase = 0;
    while (pages_queued < PAGE_COUNT) begin
      frames = (phase < $size(PHASE_FRAMES)) ? fpr_pkg::CFG_W'(PHASE_FRAMES[phase]) :
               fpr_pkg::CFG_W'($urandom_range(0, 31));
      queue_frames(frames);
      span = ((frames == '0) ? 1 :
              ((int'(frames) > fpr_pkg::FRAMES) ? fpr_pkg::FRAMES : int'(frames)))
             * $urandom_range(1, 3) + $urandom_range(0, 2);
      base = fpr_pkg::IN_W'($urandom);
      len = $urandom_range(60, 200);
      for (int k = 0; k < len && pages_queued < PAGE_COUNT; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) page = base + fpr_pkg::IN_W'($urandom_range(0, span - 1));
        else if (pick < 95) page = fpr_pkg::IN_W'($urandom);
        else page = pick[0] ? '1 : '0;
        queue_page(page);
      end
      // one hold-off mid-run with everything drained
      if (phase == 4) refs_pending.push_back('{kind: REQ_DRAIN, page: '0, frames: '0});
      phase++;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    page_req_t head;
    logic      drive_valid;
    logic      drive_we;
    logic      sender_idle;
    if (rst_n) begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      // a reference not yet taken stays on the bus unchanged
      drive_valid = in_valid && !page_xfer;
      drive_we = 1'b0;
      sender_idle = !calm && ($urandom_range(0, 99) < IDLE_PCT);
      if (!drive_valid && refs_pending.size() != 0 && !sender_idle) begin
        head = refs_pending[0];
        case (head.kind)
          REQ_PAGE: begin
            drive_valid = 1'b1;
            in_page_number <= head.page;
            void'(refs_pending.pop_front());
          end
          REQ_FRAMES: begin
            // block is idle once every prediction has been matched
            if (fault_results_due.size() == 0) begin
              drive_we = 1'b1;
              cfg_wdata <= head.frames;
              void'(refs_pending.pop_front());
            end
          end
          REQ_DRAIN: begin
            if (fault_results_due.size() == 0) void'(refs_pending.pop_front());
          end
          default: void'(refs_pending.pop_front());
        endcase
      end
      in_valid <= drive_valid;
      cfg_we <= drive_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each result transfer,
  // runs the watchdog and ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    fault_result_t want;
    logic          out_xfer;
    if (!rst_n) begin
      for (int i = 0; i < fpr_pkg::FRAMES; i++) frame_held_q[i] = 1'b0;
      fill_slot_q = 0;
      fault_total_q = '0;
      frames_cfg_q = fpr_pkg::CFG_RESET;
      page_xfer = 1'b0;
      mismatches = 0;
      cycle_no = 0;
      quiet_cycles = 0;
      settle_left = SETTLE_CYCLES;
    end else begin
      cycle_no++;
      page_xfer = in_valid && in_ready;
      out_xfer = out_valid && out_ready;

      if (cfg_we) frames_cfg_q = cfg_wdata;
      if (page_xfer) fault_results_due.push_back(fifo_lookup(in_page_number));

      if (out_xfer) begin
        if (fault_results_due.size() == 0) begin
          flag_mismatch($sformatf("result with none expected: fault=%0b count=%0d",
                                  out_fault, out_fault_count));
        end else begin
          want = fault_results_due.pop_front();
          if (out_fault !== want.fault)
            flag_mismatch($sformatf("fault: got %0b, want %0b", out_fault, want.fault));
          if (out_fault_count !== want.count)
            flag_mismatch($sformatf("fault_count: got %0d, want %0d",
                                    out_fault_count, want.count));
        end
      end

      // watchdog on cycles without any transfer
      if (page_xfer || out_xfer || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("fifo_page_replacement_unit_tb: done, errors");
        $finish;
      end else if (refs_pending.size() == 0 && !in_valid && fault_results_due.size() == 0) begin
        // everything sent and matched; let the block sit quiet a while
        settle_left--;
        if (settle_left <= 0) begin
          if (mismatches == 0) begin
            $display("fifo_page_replacement_unit_tb: done, clean");
          end else begin
            $display("fifo_page_replacement_unit_tb: done, errors");
          end
          $finish;
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
src/fpr_pkg.sv
src/fpr_ctrl.sv
src/fpr_datapath.sv
src/fifo_page_replacement_unit.sv
tb/fifo_page_replacement_unit_tb.sv
